### rtl/vadpcm_pkg.sv
// Package for the VADPCM frame decoder: sizes, command codes and helpers.
// No dependencies; imported by vadpcm_frame_decoder.
`default_nettype none
package vadpcm_pkg;
  localparam int BOOK_DEPTH    = 1024;
  localparam int BOOK_AW       = $clog2(BOOK_DEPTH);
  localparam int HIST_DEPTH    = 8;
  localparam int FRAME_SAMPLES = 16;
  localparam int UNIT_SHIFT    = 11;
  localparam int MAX_ORDER     = 8;

  typedef enum logic [1:0] {
    CMD_WR_BOOK = 2'd0,
    CMD_WR_HIST = 2'd1,
    CMD_DECODE  = 2'd2,
    CMD_CLR_HIST = 2'd3
  } cmd_t;

  function automatic logic [3:0] eff_order(input logic [3:0] o);
    if (o == 4'd0) return 4'd1;
    if (o > 4'(MAX_ORDER)) return 4'(MAX_ORDER);
    return o;
  endfunction

  function automatic logic [31:0] residual(input logic [63:0] payload,
                                           input logic [3:0] shift,
                                           input logic [3:0] idx);
    logic [3:0]  nib;
    logic [31:0] sv;
    nib = payload[{~idx, 2'b00} +: 4];
    sv  = {{28{nib[3]}}, nib};
    return sv << shift;
  endfunction

  function automatic logic [15:0] sat16(input logic [31:0] v);
    if ($signed(v) < -32'sd32768) return 16'h8000;
    if ($signed(v) > 32'sd32767) return 16'h7fff;
    return v[15:0];
  endfunction
endpackage
`default_nettype wire

### rtl/vadpcm_frame_decoder.sv
// VADPCM frame decoder top level: codebook RAM, history, shared MAC sequencer.
// Depends on vadpcm_pkg.
`default_nettype none
// After reset the block clears the 1024-entry codebook RAM, one word a cycle,
// so in_ready stays low until the clear is done. Codebook, history and clear
// commands are written as they are accepted. A decode runs one shared 16x32
// multiply-accumulate fed by the single codebook read port: each sample costs
// (order + position within its half-frame) products, and the MAC pipeline
// drains before the sample is stored; the 16 samples are then emitted
// one per cycle as out_ready allows. The last sample sits in the
// output register while the next transaction is accepted.
module vadpcm_frame_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_command,
  input  wire logic [9:0]  in_word_index,
  input  wire logic signed [15:0] in_word_value,
  input  wire logic [7:0]  in_frame_header,
  input  wire logic [63:0] in_frame_payload,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic signed [15:0] out_pcm_sample,
  output logic [3:0]       out_sample_position,
  output logic             out_last_sample,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_filter_order
);
  import vadpcm_pkg::*;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_RUN, S_WAIT, S_HIST, S_EMIT} state_t;

  state_t      state_r;
  logic [3:0]  order_cfg_r;
  logic [3:0]  ord_r;
  logic [3:0]  shift_r;
  logic [9:0]  base_r;
  logic [63:0] payload_r;
  logic [3:0]  i_r, j_r, e_r;
  logic [BOOK_AW-1:0] clr_r;
  logic        v1_r, v2_r;
  logic [31:0] op1_r, prod_r, acc_r;
  logic [15:0] rdata_r;
  logic [31:0] hist_r [HIST_DEPTH];
  logic [31:0] samp_r [FRAME_SAMPLES];
  logic        out_valid_r, out_last_r;
  logic [15:0] out_pcm_r;
  logic [3:0]  out_pos_r;

  logic [15:0] mem [BOOK_DEPTH];

  logic        in_acc;
  logic [2:0]  ii;
  logic        tap_hist, last_iss;
  logic [3:0]  t_res, widx4, ord_m1;
  logic [2:0]  tap, kk;
  logic [BOOK_AW-1:0] rd_addr, mem_wa;
  logic        mem_we;
  logic [15:0] mem_wd;
  logic [31:0] op_sel;
  logic signed [47:0] prod_full;
  logic [3:0]  ord_in;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign ord_in    = eff_order(order_cfg_r);

  assign ii       = i_r[2:0];
  assign tap_hist = (j_r < ord_r);
  assign t_res    = j_r - ord_r;
  assign ord_m1   = ord_r - 4'd1;
  assign tap      = tap_hist ? j_r[2:0] : ord_m1[2:0];
  assign kk       = tap_hist ? ii : 3'(ii - t_res[2:0] - 3'd1);
  assign rd_addr  = BOOK_AW'(base_r + {4'd0, tap, 3'd0} + {7'd0, kk});
  assign widx4    = 4'(HIST_DEPTH) - ord_r + j_r;
  assign last_iss = (j_r == 4'(ord_r + {1'b0, ii} - 4'd1));

  always_comb begin
    if (tap_hist) begin
      op_sel = i_r[3] ? samp_r[widx4[2:0]] : hist_r[widx4[2:0]];
    end else begin
      op_sel = residual(payload_r, shift_r, {i_r[3], t_res[2:0]});
    end
  end

  assign prod_full = $signed(rdata_r) * $signed(op1_r);

  assign mem_we = (state_r == S_CLR) ||
                  (in_acc && in_command == CMD_WR_BOOK);
  assign mem_wa = (state_r == S_CLR) ? clr_r : in_word_index;
  assign mem_wd = (state_r == S_CLR) ? 16'd0 : in_word_value;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    op1_r  <= op_sel;
    prod_r <= prod_full[31:0];
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      order_cfg_r <= 4'd2;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      e_r         <= '0;
      acc_r       <= '0;
      for (int k = 0; k < HIST_DEPTH; k++) hist_r[k] <= '0;
    end else begin
      v2_r <= v1_r;
      if (v2_r) acc_r <= acc_r + prod_r;
      if (cfg_valid) order_cfg_r <= cfg_filter_order;
      if (out_valid_r && out_ready && state_r != S_EMIT) out_valid_r <= 1'b0;
      v1_r <= (state_r == S_RUN);
      case (state_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == BOOK_AW'(BOOK_DEPTH - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            case (in_command)
              CMD_WR_HIST: begin
                if (in_word_index < 10'(HIST_DEPTH))
                  hist_r[in_word_index[2:0]] <= {{16{in_word_value[15]}}, in_word_value};
              end
              CMD_CLR_HIST: begin
                for (int k = 0; k < HIST_DEPTH; k++) hist_r[k] <= '0;
              end
              CMD_DECODE: begin
                ord_r     <= ord_in;
                shift_r   <= in_frame_header[7:4];
                base_r    <= {7'(in_frame_header[3:0]) * 7'(ord_in), 3'd0};
                payload_r <= in_frame_payload;
                i_r       <= '0;
                j_r       <= '0;
                acc_r     <= '0;
                state_r   <= S_RUN;
              end
              default: ;
            endcase
          end
        end
        S_RUN: begin
          j_r <= j_r + 4'd1;
          if (last_iss) state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (!v1_r && !v2_r) begin
            samp_r[i_r] <= 32'($signed(acc_r) >>> UNIT_SHIFT) +
                           residual(payload_r, shift_r, i_r);
            acc_r <= '0;
            j_r   <= '0;
            i_r   <= i_r + 4'd1;
            state_r <= (i_r == 4'(FRAME_SAMPLES - 1)) ? S_HIST : S_RUN;
          end
        end
        S_HIST: begin
          for (int k = 0; k < HIST_DEPTH; k++)
            hist_r[k] <= samp_r[FRAME_SAMPLES - HIST_DEPTH + k];
          e_r     <= '0;
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_pcm_r   <= sat16(samp_r[e_r]);
            out_pos_r   <= e_r;
            out_last_r  <= (e_r == 4'(FRAME_SAMPLES - 1));
            e_r         <= e_r + 4'd1;
            if (e_r == 4'(FRAME_SAMPLES - 1)) state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_pcm_sample      = out_pcm_r;
  assign out_sample_position = out_pos_r;
  assign out_last_sample     = out_last_r;

`ifndef SYNTH
  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_pos_r == 4'(FRAME_SAMPLES - 1))
    else $error("last flag off final position");
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !v1_r && !v2_r)
    else $error("MAC pipeline busy while idle");
  a_run_issue: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RUN |=> v1_r)
    else $error("issued product lost");
`endif
endmodule
`default_nettype wire
